[rtl/dsa_pkg.sv]
// ----------------------------------------------------------------------------
// dsa_pkg
// shared widths, controller states and the command/status bundles
// ----------------------------------------------------------------------------
package dsa_pkg;

    localparam int WORD_W        = 32;
    localparam int MANT_W        = 3 * WORD_W;
    localparam int SCALE_W       = 5;
    localparam int MAX_SCALE_DEF = 28;
    localparam int DIV_WORDS     = MANT_W / WORD_W;
    localparam int DIV_CNT_W     = $clog2(DIV_WORDS);
    localparam int REM_W         = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } dsa_state_t;

    typedef struct packed {
        logic load;
        logic mul_step;
        logic div_step;
    } dsa_cmd_t;

    typedef struct packed {
        logic differ;
        logic fits;
        logic div_last;
    } dsa_status_t;

endpackage

[rtl/dsa_ctrl.sv]
// ----------------------------------------------------------------------------
// dsa_ctrl
// sequencer: load, multiply-by-ten steps, word-serial divide-by-ten steps, emit
// ----------------------------------------------------------------------------
module dsa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  dsa_pkg::dsa_status_t status,
    output dsa_pkg::dsa_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);
    import dsa_pkg::*;

    dsa_state_t state_reg;
    dsa_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (!status.differ)
                begin
                    state_next = ST_DONE;
                end
                else if (!status.fits)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!status.differ)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_MUL:
            begin
                cmd.mul_step = status.differ & status.fits;
            end
            ST_DIV:
            begin
                cmd.div_step = status.differ;
            end
            ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

[rtl/dsa_datapath.sv]
// ----------------------------------------------------------------------------
// dsa_datapath
// operand registers, shift-add multiply by ten, word-serial divide by ten
// ----------------------------------------------------------------------------
module dsa_datapath #(
    parameter int MAX_SCALE = dsa_pkg::MAX_SCALE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dsa_pkg::dsa_cmd_t            cmd,
    output dsa_pkg::dsa_status_t         status,
    input  logic [dsa_pkg::MANT_W-1:0]   a_in,
    input  logic [dsa_pkg::SCALE_W-1:0]  a_scale_in,
    input  logic [dsa_pkg::MANT_W-1:0]   b_in,
    input  logic [dsa_pkg::SCALE_W-1:0]  b_scale_in,
    output logic [dsa_pkg::MANT_W-1:0]   a_out,
    output logic [dsa_pkg::MANT_W-1:0]   b_out,
    output logic [dsa_pkg::SCALE_W-1:0]  scale_out,
    output logic [dsa_pkg::SCALE_W-1:0]  dropped_out
);
    import dsa_pkg::*;

    localparam logic [SCALE_W-1:0] MAX_S = SCALE_W'(MAX_SCALE);
    localparam logic [DIV_CNT_W-1:0] LAST_WORD = DIV_CNT_W'(DIV_WORDS - 1);
    // 2^32 = 10 * WRAP_QUO + WRAP_REM
    localparam logic [WORD_W:0]   WRAP_REM = (WORD_W + 1)'(6);
    localparam logic [WORD_W-1:0] WRAP_QUO = 32'h1999_9999;
    // ceil(2^36 / 10), exact for numerators below 2^34
    localparam logic [WORD_W:0]   RECIP    = 33'h1_9999_999A;
    localparam int                RECIP_SH = WORD_W + 4;

    logic [MANT_W-1:0]    lo_reg;
    logic [MANT_W-1:0]    hi_reg;
    logic                 lo_is_a_reg;
    logic [SCALE_W-1:0]   lo_scale_reg;
    logic [SCALE_W-1:0]   hi_scale_reg;
    logic [SCALE_W-1:0]   dropped_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;

    logic [SCALE_W-1:0]   a_sc;
    logic [SCALE_W-1:0]   b_sc;
    logic                 a_lower;
    logic [MANT_W+3:0]    prod;
    logic [WORD_W-1:0]    q_word;
    logic [REM_W-1:0]     rem_next;

    // one long-division digit: (rem_in * 2^32 + d_in) / 10
    function automatic logic [REM_W+WORD_W-1:0] div_word(
        input logic [REM_W-1:0]  rem_in,
        input logic [WORD_W-1:0] d_in
    );
        logic [WORD_W:0]     t;
        logic [2*WORD_W+1:0] p;
        logic [WORD_W:0]     qt;
        logic [WORD_W-1:0]   q;
        logic [WORD_W:0]     r;
        t  = {1'b0, d_in} + ({{(WORD_W - REM_W + 1){1'b0}}, rem_in} * WRAP_REM);
        p  = {{(WORD_W + 1){1'b0}}, t} * {{(WORD_W + 1){1'b0}}, RECIP};
        qt = p[RECIP_SH +: WORD_W + 1];
        q  = qt[WORD_W-1:0] + ({{(WORD_W - REM_W){1'b0}}, rem_in} * WRAP_QUO);
        r  = t - ((qt << 3) + (qt << 1));
        return {r[REM_W-1:0], q};
    endfunction

    assign a_sc    = (a_scale_in > MAX_S) ? MAX_S : a_scale_in;
    assign b_sc    = (b_scale_in > MAX_S) ? MAX_S : b_scale_in;
    assign a_lower = a_sc < b_sc;

    assign prod = ({4'b0, lo_reg} << 1) + ({4'b0, lo_reg} << 3);
    assign {rem_next, q_word} = div_word(rem_reg, hi_reg[MANT_W-1 -: WORD_W]);

    assign status.differ   = lo_scale_reg != hi_scale_reg;
    assign status.fits     = prod[MANT_W+3:MANT_W] == 4'b0;
    assign status.div_last = cnt_reg == LAST_WORD;

    // control and count registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_is_a_reg  <= 1'b0;
            lo_scale_reg <= '0;
            hi_scale_reg <= '0;
            dropped_reg  <= '0;
            rem_reg      <= '0;
            cnt_reg      <= '0;
        end
        else if (cmd.load)
        begin
            lo_is_a_reg  <= a_lower;
            lo_scale_reg <= a_lower ? a_sc : b_sc;
            hi_scale_reg <= a_lower ? b_sc : a_sc;
            dropped_reg  <= '0;
            rem_reg      <= '0;
            cnt_reg      <= '0;
        end
        else if (cmd.mul_step)
        begin
            lo_scale_reg <= lo_scale_reg + 1'b1;
        end
        else if (cmd.div_step)
        begin
            if (status.div_last)
            begin
                cnt_reg      <= '0;
                rem_reg      <= '0;
                hi_scale_reg <= hi_scale_reg - 1'b1;
                dropped_reg  <= dropped_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
                rem_reg <= rem_next;
            end
        end
    end

    // mantissa registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lo_reg <= a_lower ? a_in : b_in;
            hi_reg <= a_lower ? b_in : a_in;
        end
        else if (cmd.mul_step)
        begin
            lo_reg <= prod[MANT_W-1:0];
        end
        else if (cmd.div_step)
        begin
            // quotient words shift in as dividend words shift out
            hi_reg <= {hi_reg[MANT_W-WORD_W-1:0], q_word};
        end
    end

    assign a_out       = lo_is_a_reg ? lo_reg : hi_reg;
    assign b_out       = lo_is_a_reg ? hi_reg : lo_reg;
    assign scale_out   = lo_scale_reg;
    assign dropped_out = dropped_reg;

endmodule

[rtl/decimal96_scale_align.sv]
// ----------------------------------------------------------------------------
// decimal96_scale_align
// brings two unsigned 96-bit decimal mantissas to one common scale
// ----------------------------------------------------------------------------
//  channel   | strobe / hold   | payload
//  ----------+-----------------+-------------------------------------------
//  command   | start, busy     | a_*_word, a_scale, b_*_word, b_scale
//  result    | done            | a_*_out, b_*_out, common_scale, digits_dropped
//
//  a transaction is taken when start is high and busy is low; busy stays high
//  until the result has been shown. the sequencer runs multiply-by-ten steps
//  and, once the product no longer fits, divide-by-ten steps; the word-serial
//  divider yields one 32-bit quotient word a cycle. the next transaction can
//  be taken once the sequencer has returned to idle after done. done is high
//  for one cycle with the result; the receiver cannot stall. rst_n clears the
//  sequencer asynchronously.
// ----------------------------------------------------------------------------
module decimal96_scale_align #(
    parameter int MAX_SCALE = dsa_pkg::MAX_SCALE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [dsa_pkg::WORD_W-1:0]    a_low_word,
    input  logic [dsa_pkg::WORD_W-1:0]    a_mid_word,
    input  logic [dsa_pkg::WORD_W-1:0]    a_high_word,
    input  logic [dsa_pkg::SCALE_W-1:0]   a_scale,
    input  logic [dsa_pkg::WORD_W-1:0]    b_low_word,
    input  logic [dsa_pkg::WORD_W-1:0]    b_mid_word,
    input  logic [dsa_pkg::WORD_W-1:0]    b_high_word,
    input  logic [dsa_pkg::SCALE_W-1:0]   b_scale,
    output logic                          done,
    output logic [dsa_pkg::WORD_W-1:0]    a_low_out,
    output logic [dsa_pkg::WORD_W-1:0]    a_mid_out,
    output logic [dsa_pkg::WORD_W-1:0]    a_high_out,
    output logic [dsa_pkg::WORD_W-1:0]    b_low_out,
    output logic [dsa_pkg::WORD_W-1:0]    b_mid_out,
    output logic [dsa_pkg::WORD_W-1:0]    b_high_out,
    output logic [dsa_pkg::SCALE_W-1:0]   common_scale,
    output logic [dsa_pkg::SCALE_W-1:0]   digits_dropped
);
    import dsa_pkg::*;

    dsa_cmd_t          cmd;
    dsa_status_t       status;
    logic [MANT_W-1:0] a_mant;
    logic [MANT_W-1:0] b_mant;

    dsa_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    dsa_datapath #(
        .MAX_SCALE (MAX_SCALE)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .a_in        ({a_high_word, a_mid_word, a_low_word}),
        .a_scale_in  (a_scale),
        .b_in        ({b_high_word, b_mid_word, b_low_word}),
        .b_scale_in  (b_scale),
        .a_out       (a_mant),
        .b_out       (b_mant),
        .scale_out   (common_scale),
        .dropped_out (digits_dropped)
    );

    assign a_low_out  = a_mant[WORD_W-1:0];
    assign a_mid_out  = a_mant[2*WORD_W-1:WORD_W];
    assign a_high_out = a_mant[MANT_W-1:2*WORD_W];
    assign b_low_out  = b_mant[WORD_W-1:0];
    assign b_mid_out  = b_mant[2*WORD_W-1:WORD_W];
    assign b_high_out = b_mant[MANT_W-1:2*WORD_W];

endmodule

[sim/scale_align_checker.sv]
// ----------------------------------------------------------------------------
// scale_align_checker
// watches the command and result channels of decimal96_scale_align, works
// out the aligned mantissas, common scale and dropped digits for every
// accepted transaction and compares them field by field with each result
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module scale_align_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [dsa_pkg::WORD_W-1:0]  a_low_word,
    input  logic [dsa_pkg::WORD_W-1:0]  a_mid_word,
    input  logic [dsa_pkg::WORD_W-1:0]  a_high_word,
    input  logic [dsa_pkg::SCALE_W-1:0] a_scale,
    input  logic [dsa_pkg::WORD_W-1:0]  b_low_word,
    input  logic [dsa_pkg::WORD_W-1:0]  b_mid_word,
    input  logic [dsa_pkg::WORD_W-1:0]  b_high_word,
    input  logic [dsa_pkg::SCALE_W-1:0] b_scale,
    input  logic                        done,
    input  logic [dsa_pkg::WORD_W-1:0]  a_low_out,
    input  logic [dsa_pkg::WORD_W-1:0]  a_mid_out,
    input  logic [dsa_pkg::WORD_W-1:0]  a_high_out,
    input  logic [dsa_pkg::WORD_W-1:0]  b_low_out,
    input  logic [dsa_pkg::WORD_W-1:0]  b_mid_out,
    input  logic [dsa_pkg::WORD_W-1:0]  b_high_out,
    input  logic [dsa_pkg::SCALE_W-1:0] common_scale,
    input  logic [dsa_pkg::SCALE_W-1:0] digits_dropped,
    output int                          mismatches,
    output int                          outstanding
);
    import dsa_pkg::*;

    typedef struct packed {
        logic [MANT_W-1:0]  a;
        logic [MANT_W-1:0]  b;
        logic [SCALE_W-1:0] scale;
        logic [SCALE_W-1:0] dropped;
    } aligned_t;

    aligned_t pending_alignments[$];
    int       mismatch_count;
    int       awaiting;

    assign mismatches  = mismatch_count;
    assign outstanding = awaiting;

    function automatic int saturate_scale(logic [SCALE_W-1:0] s);
        return (s > MAX_SCALE_DEF) ? MAX_SCALE_DEF : int'(s);
    endfunction

    function automatic aligned_t align_operands(logic [MANT_W-1:0] a_m, logic [SCALE_W-1:0] a_s,
                                                logic [MANT_W-1:0] b_m, logic [SCALE_W-1:0] b_s);
        logic [MANT_W-1:0]   lo_m;
        logic [MANT_W-1:0]   hi_m;
        logic [MANT_W+3:0]   prod;
        int                  lo_s;
        int                  hi_s;
        int                  drops;
        bit                  a_is_lo;
        aligned_t            r;
        a_is_lo = saturate_scale(a_s) < saturate_scale(b_s);
        lo_m    = a_is_lo ? a_m : b_m;
        hi_m    = a_is_lo ? b_m : a_m;
        lo_s    = a_is_lo ? saturate_scale(a_s) : saturate_scale(b_s);
        hi_s    = a_is_lo ? saturate_scale(b_s) : saturate_scale(a_s);
        drops   = 0;
        // scale the smaller-exponent side up while the product still fits
        while (lo_s < hi_s)
        begin
            prod = ({4'b0, lo_m} << 3) + ({4'b0, lo_m} << 1);
            if (prod[MANT_W+3:MANT_W] != 0)
                break;
            lo_m = prod[MANT_W-1:0];
            lo_s++;
        end
        // truncate the larger-exponent side for what is left
        while (hi_s > lo_s)
        begin
            hi_m = hi_m / 10;
            hi_s--;
            drops++;
        end
        r.a       = a_is_lo ? lo_m : hi_m;
        r.b       = a_is_lo ? hi_m : lo_m;
        r.scale   = SCALE_W'(lo_s);
        r.dropped = SCALE_W'(drops);
        return r;
    endfunction

    task automatic flag(string field, logic [MANT_W-1:0] want, logic [MANT_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s expected %h got %h", $realtime, field, want, got);
    endtask

    always @(posedge clk)
    begin
        aligned_t want;
        aligned_t got;
        if (rst_n && start && !busy)
            pending_alignments.push_back(align_operands(
                {a_high_word, a_mid_word, a_low_word}, a_scale,
                {b_high_word, b_mid_word, b_low_word}, b_scale));
        if (rst_n && done)
        begin
            got.a       = {a_high_out, a_mid_out, a_low_out};
            got.b       = {b_high_out, b_mid_out, b_low_out};
            got.scale   = common_scale;
            got.dropped = digits_dropped;
            if (pending_alignments.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with no transaction pending", $realtime);
            end
            else
            begin
                want = pending_alignments.pop_front();
                if (got.a !== want.a)
                    flag("a mantissa", want.a, got.a);
                if (got.b !== want.b)
                    flag("b mantissa", want.b, got.b);
                if (got.scale !== want.scale)
                    flag("common_scale", want.scale, got.scale);
                if (got.dropped !== want.dropped)
                    flag("digits_dropped", want.dropped, got.dropped);
            end
        end
        awaiting = pending_alignments.size();
    end

endmodule

[sim/decimal96_scale_align_test.sv]
// ----------------------------------------------------------------------------
// decimal96_scale_align_test
// drives directed and random mantissa pairs with random idle gaps into
// decimal96_scale_align and reports the verdict from the attached checker
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module decimal96_scale_align_test;

    import dsa_pkg::*;

    localparam logic [MANT_W-1:0] ALL_ONES = '1;
    localparam logic [MANT_W-1:0] ALT_A    = {3{32'hAAAA_AAAA}};
    localparam logic [MANT_W-1:0] ALT_5    = {3{32'h5555_5555}};

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [WORD_W-1:0]  a_low_word;
    logic [WORD_W-1:0]  a_mid_word;
    logic [WORD_W-1:0]  a_high_word;
    logic [SCALE_W-1:0] a_scale;
    logic [WORD_W-1:0]  b_low_word;
    logic [WORD_W-1:0]  b_mid_word;
    logic [WORD_W-1:0]  b_high_word;
    logic [SCALE_W-1:0] b_scale;
    logic               done;
    logic [WORD_W-1:0]  a_low_out;
    logic [WORD_W-1:0]  a_mid_out;
    logic [WORD_W-1:0]  a_high_out;
    logic [WORD_W-1:0]  b_low_out;
    logic [WORD_W-1:0]  b_mid_out;
    logic [WORD_W-1:0]  b_high_out;
    logic [SCALE_W-1:0] common_scale;
    logic [SCALE_W-1:0] digits_dropped;
    int                 mismatches;
    int                 outstanding;
    bit                 no_gaps;

    decimal96_scale_align uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .a_low_word     (a_low_word),
        .a_mid_word     (a_mid_word),
        .a_high_word    (a_high_word),
        .a_scale        (a_scale),
        .b_low_word     (b_low_word),
        .b_mid_word     (b_mid_word),
        .b_high_word    (b_high_word),
        .b_scale        (b_scale),
        .done           (done),
        .a_low_out      (a_low_out),
        .a_mid_out      (a_mid_out),
        .a_high_out     (a_high_out),
        .b_low_out      (b_low_out),
        .b_mid_out      (b_mid_out),
        .b_high_out     (b_high_out),
        .common_scale   (common_scale),
        .digits_dropped (digits_dropped)
    );

    scale_align_checker check_u (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .a_low_word     (a_low_word),
        .a_mid_word     (a_mid_word),
        .a_high_word    (a_high_word),
        .a_scale        (a_scale),
        .b_low_word     (b_low_word),
        .b_mid_word     (b_mid_word),
        .b_high_word    (b_high_word),
        .b_scale        (b_scale),
        .done           (done),
        .a_low_out      (a_low_out),
        .a_mid_out      (a_mid_out),
        .a_high_out     (a_high_out),
        .b_low_out      (b_low_out),
        .b_mid_out      (b_mid_out),
        .b_high_out     (b_high_out),
        .common_scale   (common_scale),
        .digits_dropped (digits_dropped),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // random mantissa with at most the given number of significant bits
    function automatic logic [MANT_W-1:0] mantissa_of_width(int bits);
        logic [MANT_W-1:0] m;
        m = {$urandom, $urandom, $urandom};
        return (bits <= 0) ? '0 : m >> (MANT_W - bits);
    endfunction

    function automatic logic [MANT_W-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return 96'd1;
            default: return {$urandom, $urandom, $urandom};
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] pick_edge_scale();
        case ($urandom_range(0, 3))
            0:       return 5'd0;
            1:       return 5'd28;
            2:       return 5'd29;
            default: return 5'd31;
        endcase
    endfunction

    // one transaction: idle gap, then hold start until the block takes it
    task automatic align_pair(logic [MANT_W-1:0] a_m, logic [SCALE_W-1:0] a_s,
                              logic [MANT_W-1:0] b_m, logic [SCALE_W-1:0] b_s);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        {a_high_word, a_mid_word, a_low_word} = a_m;
        {b_high_word, b_mid_word, b_low_word} = b_m;
        a_scale = a_s;
        b_scale = b_s;
        start   = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        logic [MANT_W-1:0]  a_m;
        logic [MANT_W-1:0]  b_m;
        logic [SCALE_W-1:0] a_s;
        logic [SCALE_W-1:0] b_s;
        int                 low_side;
        rst_n       = 1'b0;
        start       = 1'b0;
        no_gaps     = 1'b0;
        a_low_word  = '0;
        a_mid_word  = '0;
        a_high_word = '0;
        a_scale     = '0;
        b_low_word  = '0;
        b_mid_word  = '0;
        b_high_word = '0;
        b_scale     = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed
        align_pair('0, 5'd0, '0, 5'd0);
        align_pair(ALL_ONES, 5'd28, ALL_ONES, 5'd28);
        align_pair(96'd1, 5'd0, 96'd1, 5'd28);
        align_pair(ALL_ONES, 5'd0, ALL_ONES, 5'd28);
        align_pair(ALL_ONES, 5'd28, 96'd1, 5'd0);
        align_pair(96'd123456789, 5'd31, 96'd987654321, 5'd0);
        align_pair(96'd42, 5'd29, 96'd17, 5'd30);
        align_pair(96'd5, 5'd3, 96'd7, 5'd3);
        align_pair(96'd1 << 80, 5'd0, 96'd12345, 5'd10);
        align_pair(96'd12345, 5'd12, 96'd1 << 85, 5'd2);
        align_pair('0, 5'd0, ALL_ONES, 5'd28);
        align_pair(ALL_ONES, 5'd5, '0, 5'd6);
        align_pair(ALL_ONES, 5'd31, ALL_ONES, 5'd31);
        align_pair(ALT_A, 5'd21, ALT_5, 5'd10);
        align_pair(ALT_5, 5'd10, ALT_A, 5'd21);
        align_pair(96'd999, 5'd1, 96'd1, 5'd31);
        align_pair(ALL_ONES >> 4, 5'd0, 96'd3, 5'd1);

        // random
        for (int n = 0; n < 1050; n++)
        begin
            if ($urandom_range(0, 49) == 0)
                no_gaps = ~no_gaps;
            a_s = 5'($urandom_range(0, 28));
            b_s = 5'($urandom_range(0, 28));
            a_m = mantissa_of_width($urandom_range(0, 96));
            b_m = mantissa_of_width($urandom_range(0, 96));
            case ($urandom_range(0, 9))
                4, 5:
                begin
                    a_m = {$urandom, $urandom, $urandom};
                    b_m = {$urandom, $urandom, $urandom};
                    a_s = 5'($urandom_range(0, 31));
                    b_s = 5'($urandom_range(0, 31));
                end
                6:
                    b_s = a_s;
                7:
                begin
                    // small low-scale operand, many multiply steps
                    low_side = $urandom_range(0, 1);
                    if (low_side == 0)
                    begin
                        a_m = mantissa_of_width($urandom_range(0, 24));
                        a_s = 5'($urandom_range(0, 6));
                        b_s = 5'($urandom_range(20, 31));
                    end
                    else
                    begin
                        b_m = mantissa_of_width($urandom_range(0, 24));
                        b_s = 5'($urandom_range(0, 6));
                        a_s = 5'($urandom_range(20, 31));
                    end
                end
                8:
                begin
                    // low-scale operand overflows partway through
                    a_m = mantissa_of_width($urandom_range(60, 96));
                    a_s = 5'($urandom_range(0, 10));
                    b_s = 5'($urandom_range(15, 28));
                end
                9:
                begin
                    a_m = pick_extreme();
                    b_m = pick_extreme();
                    a_s = pick_edge_scale();
                    b_s = pick_edge_scale();
                end
                default:
                    ;
            endcase
            align_pair(a_m, a_s, b_m, b_s);
        end
        start = 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (400) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[files.f]
rtl/dsa_pkg.sv
rtl/dsa_ctrl.sv
rtl/dsa_datapath.sv
rtl/decimal96_scale_align.sv
sim/scale_align_checker.sv
sim/decimal96_scale_align_test.sv
